FILE: rtl/cht_pkg.sv
package cht_pkg;

  localparam logic [1:0] CMD_STORE = 2'd0;
  localparam logic [1:0] CMD_PROBE = 2'd1;
  localparam logic [1:0] CMD_PV    = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] FLAG_EXACT = 2'd0;
  localparam logic [1:0] FLAG_UPPER = 2'd1;
  localparam logic [1:0] FLAG_LOWER = 2'd2;

  localparam int AGE_SHIFT = 2;
  localparam logic [0:0] REG_GENERATION = 1'd0;
  localparam logic [0:0] REG_MATE_BOUND = 1'd1;
  localparam logic [14:0] MATE_BOUND_RST = 15'd31000;

  typedef struct packed {
    logic [63:0]        key;
    logic signed [15:0] score;
    logic [7:0]         depth;
    logic [1:0]         flag;
    logic [7:0]         gen;
    logic [15:0]        move;
    logic [3:0]         piece;
  } slot_t;

  typedef struct packed {
    logic [3:0]         move_piece;
    logic [15:0]        move_code;
    logic               move_valid;
    logic [1:0]         bound_kind;
    logic signed [15:0] beta;
    logic signed [15:0] alpha;
    logic signed [8:0]  depth;
    logic [7:0]         ply;
    logic signed [15:0] score;
    logic [63:0]        key;
  } item_t;

  typedef struct packed {
    logic [6:0]         pad;
    logic [3:0]         move_piece_out;
    logic [15:0]        move_code_out;
    logic               move_present;
    logic [1:0]         flag_out;
    logic [7:0]         depth_out;
    logic signed [15:0] score_out;
    logic               cutoff;
    logic               hit;
  } result_t;

  // mate score ply shift; toward_root subtracts ply from positive scores
  function automatic logic signed [15:0] mate_adjust(logic signed [15:0] s, logic [7:0] ply,
                                                     logic [14:0] mb, logic toward_root);
    logic [16:0]        mag;
    logic signed [17:0] wide;
    logic               up;
    mag  = s[15] ? 17'(-$signed({s[15], s})) : {1'b0, s};
    up   = (s > 16'sd0) ^ toward_root;
    wide = up ? 18'(s) + $signed({10'd0, ply}) : 18'(s) - $signed({10'd0, ply});
    if (mag <= {2'b00, mb}) return s;
    if (wide > 18'sd32767) return 16'sh7fff;
    if (wide < -18'sd32768) return 16'sh8000;
    return wide[15:0];
  endfunction

endpackage

FILE: rtl/clustered_hash_table_with_aging_unit.sv
// Set-associative search result table with replacement by age and depth.
// Input stream s_*: one transaction per command (store, probe, principal
// move query, clear); the command travels in s_tuser, the rest in s_tdata.
// Output stream m_*: exactly one result transaction per command.
// Configuration: cfg_we writes generation (index 0) or mate_bound (index 1);
// the user must do so only while the unit is idle; the unit does not enforce it.
// The cluster is read from a one-port synchronous memory at accept, then,
// for a store, updated and written back while the result is loaded into
// the output register. A new command is accepted only once the one in
// flight is through, set by the read-modify-write of the cluster memory.
// Reset and the clear command sweep the memory one cluster a cycle, over all
// 2^INDEX_BITS clusters (4096 by default), during which s_tready stays low.
// The clear result is issued before the sweep. If the output is stalled,
// the command in flight waits with its write-back until the result is taken.
module clustered_hash_table_with_aging_unit #(
  parameter int INDEX_BITS = 12,
  parameter int WAYS       = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // key, score, ply, depth, alpha, beta, bound_kind, move_valid, move_code, move_piece
  input  logic [151:0] s_tdata,
  // command
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit, cutoff, score_out, depth_out, flag_out, move_present, move_code_out,
  // move_piece_out, zero fill
  output logic [55:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [14:0]  cfg_data
);
  import cht_pkg::*;

  localparam int CLUSTERS = 1 << INDEX_BITS;
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  slot_t [WAYS-1:0] mem [CLUSTERS];
  slot_t [WAYS-1:0] rd_q;
  slot_t [WAYS-1:0] cl_next;
  slot_t [WAYS-1:0] wr_data;
  logic [1:0]       state;
  logic [INDEX_BITS-1:0] clear_ptr;
  logic [INDEX_BITS-1:0] wr_addr;
  logic             mem_we;
  logic             go;
  logic [7:0]       generation;
  logic [14:0]      mate_bound;
  item_t            item;
  logic [1:0]       command;
  result_t          res;

  assign s_tready = (state == ST_IDLE);
  assign go       = (state == ST_EXEC) && (!m_tvalid || m_tready);
  assign mem_we   = (go && command == CMD_STORE) || (state == ST_CLEAR);
  assign wr_addr  = (state == ST_CLEAR) ? clear_ptr : item.key[INDEX_BITS-1:0];
  assign wr_data  = (state == ST_CLEAR) ? '0 : cl_next;

  cht_update #(.WAYS(WAYS)) u_update (
    .cl(rd_q), .item(item), .command(command), .generation(generation),
    .mate_bound(mate_bound), .cl_next(cl_next), .res(res)
  );

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rd_q <= mem[s_tdata[INDEX_BITS-1:0]];
      item <= item_t'(s_tdata);
      command <= s_tuser;
    end
    if (mem_we) mem[wr_addr] <= wr_data;
    if (go) m_tdata <= 56'(res);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_ptr  <= '0;
      m_tvalid   <= 1'b0;
      generation <= 8'd0;
      mate_bound <= MATE_BOUND_RST;
    end else begin
      if (go) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (go && command == CMD_CLEAR) generation <= 8'd0;
      else if (cfg_we && cfg_index == REG_GENERATION) generation <= cfg_data[7:0];
      if (cfg_we && cfg_index == REG_MATE_BOUND) mate_bound <= cfg_data;
      unique case (state)
        ST_IDLE: if (s_tvalid) state <= ST_EXEC;
        ST_EXEC: begin
          if (go) begin
            if (command == CMD_CLEAR) begin
              state      <= ST_CLEAR;
              clear_ptr  <= '0;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_CLEAR: begin
          clear_ptr <= clear_ptr + 1'b1;
          if (&clear_ptr) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_EXEC) else $error("accept did not start execution");
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == ST_EXEC || state == ST_CLEAR) else $error("memory write while idle");
  a_clear_gen: assert property (@(posedge clk) disable iff (rst)
    go && command == CMD_CLEAR |=> generation == 8'd0 && state == ST_CLEAR)
    else $error("clear did not reset generation");
  a_out_after_go: assert property (@(posedge clk) disable iff (rst)
    go |=> m_tvalid) else $error("result not issued");

endmodule

FILE: rtl/cht_update.sv
module cht_update #(
  parameter int WAYS = 4
) (
  input  cht_pkg::slot_t [WAYS-1:0] cl,
  input  cht_pkg::item_t            item,
  input  logic [1:0]                command,
  input  logic [7:0]                generation,
  input  logic [14:0]               mate_bound,
  output cht_pkg::slot_t [WAYS-1:0] cl_next,
  output cht_pkg::result_t          res
);
  import cht_pkg::*;

  localparam int PW = (WAYS > 1) ? $clog2(WAYS) : 1;

  always_comb begin
    logic              found;
    logic              phit;
    logic [PW-1:0]     pick;
    logic [PW-1:0]     ph;
    logic signed [10:0] bad;
    logic signed [10:0] worst;
    logic [7:0]        age;
    logic [7:0]        dcl;
    logic signed [15:0] ws;
    logic signed [15:0] r;
    slot_t             e;
    found = 1'b0;
    phit  = 1'b0;
    pick  = '0;
    ph    = '0;
    worst = -11'sd1024;
    e     = '0;
    r     = '0;
    for (int i = 0; i < WAYS; i++) begin
      age = generation - cl[i].gen;
      bad = $signed(11'(age) << AGE_SHIFT) - $signed({3'b000, cl[i].depth});
      if (!found) begin
        if (cl[i].key == item.key || cl[i].key == '0) begin
          found = 1'b1;
          pick  = PW'(i);
        end else if (bad > worst) begin
          worst = bad;
          pick  = PW'(i);
        end
      end
      if (!phit && cl[i].key == item.key) begin
        phit = 1'b1;
        ph   = PW'(i);
      end
    end
    dcl     = item.depth[8] ? 8'd0 : item.depth[7:0];
    ws      = mate_adjust(item.score, item.ply, mate_bound, 1'b0);
    cl_next = cl;
    res     = '0;
    case (command)
      CMD_STORE: begin
        e = cl[pick];
        if (e.key == item.key) begin
          res.hit = 1'b1;
          e.gen = generation;
          if (item.move_valid) begin
            e.move  = item.move_code;
            e.piece = item.move_piece;
          end
          if (dcl >= e.depth) begin
            e.score = ws;
            e.depth = dcl;
            e.flag  = item.bound_kind;
          end
        end else begin
          e.key   = item.key;
          e.score = ws;
          e.depth = dcl;
          e.flag  = item.bound_kind;
          e.gen   = generation;
          e.move  = item.move_valid ? item.move_code : 16'd0;
          e.piece = item.move_valid ? item.move_piece : 4'd0;
        end
        cl_next[pick] = e;
      end
      CMD_PROBE: begin
        e = cl[ph];
        r = mate_adjust(e.score, item.ply, mate_bound, 1'b1);
        if (phit) begin
          res.hit       = 1'b1;
          res.score_out = r;
          res.depth_out = e.depth;
          res.flag_out  = e.flag;
          if ($signed({2'b00, e.depth}) >= $signed({item.depth[8], item.depth})) begin
            res.cutoff = (e.flag == FLAG_EXACT) || (e.flag == FLAG_UPPER && r <= item.alpha)
                      || (e.flag == FLAG_LOWER && r >= item.beta);
          end
          if (e.move != '0) begin
            res.move_present   = 1'b1;
            res.move_code_out  = e.move;
            res.move_piece_out = e.piece;
          end
        end
      end
      CMD_PV: begin
        e = cl[ph];
        res.hit = phit;
        if (phit && e.flag == FLAG_EXACT && e.move != '0) begin
          res.move_present   = 1'b1;
          res.move_code_out  = e.move;
          res.move_piece_out = e.piece;
        end
      end
      default: ;
    endcase
  end

endmodule
